### design/hcp_pkg.sv
// Shared types, constants and helpers for the HSL colorize pixel unit.
package hcp_pkg;

	typedef logic [7:0] chan_t;

	// APB register indexes (byte address / 4)
	localparam logic [1:0] REG_HUE   = 2'd0;
	localparam logic [1:0] REG_SAT   = 2'd1;
	localparam logic [1:0] REG_LIGHT = 2'd2;
	localparam logic [1:0] REG_ALPHA = 2'd3;

	localparam logic [8:0] HUE_RST   = 9'd180;
	localparam logic [6:0] SAT_RST   = 7'd50;
	localparam logic [7:0] LIGHT_RST = 8'd0;

	// Rec.709 luma weights, Q0.16
	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;

	// reciprocals: floor(n/100) = n*R >> 19 for n <= 25400
	localparam logic [12:0] RCP100_LUM = 13'd5243;
	// floor(n/20) = n*R >> 16 for n < 5120
	localparam logic [11:0] RCP20      = 12'd3277;
	// floor(n/100) = n*R >> 30 for n < 2^23
	localparam logic [23:0] RCP100_SAT = 24'd10737419;
	// floor(n/60) = n*R >> 28 for n < 2^22
	localparam logic [22:0] RCP60      = 23'd4473925;

	localparam logic [16:0] Q_ONE  = 17'd65536;
	localparam logic [16:0] Q_HALF = 17'd32768;

	// ramp weight (0..60) of a hue position in degrees
	function automatic logic [5:0] hue_weight(input logic [9:0] p);
		logic [5:0] w;
		if (p < 10'd60) begin
			w = p[5:0];
		end else if (p < 10'd180) begin
			w = 6'd60;
		end else if (p < 10'd240) begin
			w = 6'(10'd240 - p);
		end else begin
			w = 6'd0;
		end
		return w;
	endfunction

endpackage

### design/hcp_if.sv
// Valid/ready stream interfaces for source pixels and colorized pixels.
interface hcp_in_if;
	import hcp_pkg::*;

	logic  valid;
	logic  ready;
	chan_t red_in;
	chan_t green_in;
	chan_t blue_in;
	chan_t alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface hcp_out_if;
	import hcp_pkg::*;

	logic  valid;
	logic  ready;
	chan_t red_out;
	chan_t green_out;
	chan_t blue_out;
	chan_t alpha_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

### design/hsl_colorize_pixel_unit.sv
// HSL colorize pixel unit: six-stage pipeline that tints RGB(A) pixels.
//
// pixel (sink): one source RGBA word per handshake (valid & ready at clk rise).
// tinted (source): one colorized word per source word, in order.
// APB port: hue (0x0), saturation (0x4), lightness (0x8), alpha enable (0xC);
// pready is tied high, reads return the stored register bits.
// Throughput: one word per cycle while tinted.ready is high. Six register
// stages: luma, lightness scale, lightness divide, HSL bound, ramp multiply
// and output multiply; a word taken on pixel is offered on tinted from the
// last of them.
// Register changes are meant for an empty pipeline; values derived from the
// registers are refreshed every cycle.
// When tinted.ready is low, words hold in place and bubbles close up; pixel
// ready drops only when all six stages are full. Nothing is dropped or doubled.
// arst_n clears all stage valid bits and loads hue 180, saturation 50,
// lightness 0, alpha disabled.
module hsl_colorize_pixel_unit (
	input  logic          clk,
	input  logic          arst_n,
	hcp_in_if.sink        pixel,
	hcp_out_if.source     tinted,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import hcp_pkg::*;

	// registers
	logic [8:0] hue_q;
	logic [6:0] sat_q;
	logic [7:0] light_q;
	logic       alpha_en_q;
	logic       cfg_wr;
	logic [1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q      <= HUE_RST;
			sat_q      <= SAT_RST;
			light_q    <= LIGHT_RST;
			alpha_en_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_HUE:   hue_q      <= pwdata[8:0];
				REG_SAT:   sat_q      <= pwdata[6:0];
				REG_LIGHT: light_q    <= pwdata[7:0];
				REG_ALPHA: alpha_en_q <= pwdata[0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_HUE:   prdata = {23'd0, hue_q};
			REG_SAT:   prdata = {25'd0, sat_q};
			REG_LIGHT: prdata = {24'd0, light_q};
			REG_ALPHA: prdata = {31'd0, alpha_en_q};
			default:   prdata = 32'd0;
		endcase
	end

	// values derived from the registers
	logic [8:0]  hue_c;
	logic [9:0]  pos_r, pos_g, pos_b;
	logic [6:0]  sat_c;
	logic [22:0] sat_n;
	logic [46:0] sat_p;
	logic signed [7:0] lt_c;
	logic [6:0]  k_c;
	logic        over_c;
	logic [12:0] ce_n;
	logic [24:0] ce_p;
	logic [12:0] oc_n;
	logic [25:0] oc_p;
	logic [7:0]  off_c;
	logic [6:0]  k_q;
	logic        over_q;
	logic [7:0]  off_q;
	logic [16:0] s_q;
	logic [28:0] cr_q, cg_q, cb_q;

	always_comb begin
		hue_c = (hue_q >= 9'd360) ? 9'(hue_q - 9'd360) : hue_q;
		pos_r = 10'(hue_c) + 10'd120;
		if (pos_r > 10'd360) begin
			pos_r = pos_r - 10'd360;
		end
		pos_g = 10'(hue_c);
		pos_b = (hue_c < 9'd120) ? 10'(hue_c) + 10'd240 : 10'(hue_c) - 10'd120;

		sat_c = (sat_q > 7'd100) ? 7'd100 : sat_q;
		sat_n = {sat_c, 16'd0} + 23'd50;
		sat_p = 47'(sat_n) * 47'(RCP100_SAT);

		lt_c = $signed(light_q);
		if (lt_c < -8'sd100) begin
			lt_c = -8'sd100;
		end
		// lightness above 100 wraps the 32-bit scale factor; k holds the excess
		over_c = (lt_c > 8'sd100);
		if (over_c) begin
			k_c = 7'(lt_c - 8'sd100);
		end else if (lt_c > 8'sd0) begin
			k_c = 7'(8'sd100 - lt_c);
		end else if (lt_c < 8'sd0) begin
			k_c = 7'(lt_c + 8'sd100);
		end else begin
			k_c = 7'd100;
		end
		ce_n  = 13'(k_c) * 13'd51 + 13'd19;
		ce_p  = 25'(ce_n) * 25'(RCP20);
		oc_n  = 13'(k_c) * 13'd255 - 13'd96;
		oc_p  = 26'(oc_n) * 26'(RCP100_LUM);
		if (over_c) begin
			off_c = 8'(9'd255 + 9'(oc_p[25:19]));
		end else if (lt_c > 8'sd0) begin
			off_c = 8'(9'd255 - ce_p[24:16]);
		end else begin
			off_c = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		k_q    <= k_c;
		over_q <= over_c;
		off_q  <= off_c;
		s_q    <= sat_p[46:30];
		cr_q   <= 29'(hue_weight(pos_r)) * 29'(RCP60);
		cg_q   <= 29'(hue_weight(pos_g)) * 29'(RCP60);
		cb_q   <= 29'(hue_weight(pos_b)) * 29'(RCP60);
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic take1, take2, take3, take4, take5, take6;

	assign take6 = !v_s6 || tinted.ready;
	assign take5 = !v_s5 || take6;
	assign take4 = !v_s4 || take5;
	assign take3 = !v_s3 || take4;
	assign take2 = !v_s2 || take3;
	assign take1 = !v_s1 || take2;
	assign pixel.ready  = take1;
	assign tinted.valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (take1) v_s1 <= pixel.valid;
			if (take2) v_s2 <= v_s1;
			if (take3) v_s3 <= v_s2;
			if (take4) v_s4 <= v_s3;
			if (take5) v_s5 <= v_s4;
			if (take6) v_s6 <= v_s5;
		end
	end

	// datapath
	logic [23:0] prod_r, prod_g, prod_b;
	logic [27:0] div_p;
	logic [7:0]  lum_c;
	logic [33:0] ls_p;
	logic [17:0] ls_h, m2_c, m1_c;
	logic [45:0] qr_p, qg_p, qb_p;
	logic [16:0] vr_c, vg_c, vb_c;
	logic [24:0] or_p, og_p, ob_p;

	logic [7:0]  lum_s1, alpha_s1;
	logic [14:0] kp_s2;
	logic        lz_s2;
	logic [7:0]  alpha_s2;
	logic [7:0]  lum_s3, alpha_s3;
	logic [16:0] l_s3;
	logic [16:0] m1_s4, d_s4;
	logic [7:0]  lum_s4, alpha_s4;
	logic [16:0] m1_s5, qr_s5, qg_s5, qb_s5;
	logic [7:0]  lum_s5, alpha_s5;
	chan_t       red_s6, green_s6, blue_s6, alpha_s6;

	always_comb begin
		prod_r = 24'(pixel.red_in) * 24'(W_RED);
		prod_g = 24'(pixel.green_in) * 24'(W_GREEN);
		prod_b = 24'(pixel.blue_in) * 24'(W_BLUE);

		div_p = 28'(kp_s2) * 28'(RCP100_LUM);
		if (over_q) begin
			lum_c = 8'(9'(off_q) - div_p[27:19] - (lz_s2 ? 9'd40 : 9'd0));
		end else begin
			lum_c = 8'(div_p[27:19] + 9'(off_q));
		end

		ls_p = 34'(l_s3) * 34'(s_q);
		ls_h = ls_p[33:16];
		if (l_s3 <= Q_HALF) begin
			m2_c = 18'(l_s3) + ls_h;
		end else begin
			m2_c = 18'(l_s3) + 18'(s_q) - ls_h;
		end
		m1_c = {l_s3, 1'b0} - m2_c;

		qr_p = 46'(d_s4) * 46'(cr_q);
		qg_p = 46'(d_s4) * 46'(cg_q);
		qb_p = 46'(d_s4) * 46'(cb_q);

		vr_c = m1_s5 + qr_s5;
		vg_c = m1_s5 + qg_s5;
		vb_c = m1_s5 + qb_s5;
		or_p = 25'(lum_s5) * 25'(vr_c);
		og_p = 25'(lum_s5) * 25'(vg_c);
		ob_p = 25'(lum_s5) * 25'(vb_c);
	end

	always_ff @(posedge clk) begin
		if (take1) begin
			lum_s1   <= 8'(prod_r[23:16] + prod_g[23:16] + prod_b[23:16]);
			alpha_s1 <= alpha_en_q ? pixel.alpha_in : 8'd0;
		end
		if (take2) begin
			kp_s2    <= 15'(lum_s1) * 15'(k_q) + (over_q ? 15'd3 : 15'd0);
			lz_s2    <= (lum_s1 == 8'd0);
			alpha_s2 <= alpha_s1;
		end
		if (take3) begin
			lum_s3   <= lum_c;
			l_s3     <= 17'({lum_c, lum_c}) + 17'(lum_c[7]);
			alpha_s3 <= alpha_s2;
		end
		if (take4) begin
			m1_s4    <= m1_c[16:0];
			d_s4     <= 17'(m2_c - m1_c);
			lum_s4   <= lum_s3;
			alpha_s4 <= alpha_s3;
		end
		if (take5) begin
			m1_s5    <= m1_s4;
			qr_s5    <= qr_p[44:28];
			qg_s5    <= qg_p[44:28];
			qb_s5    <= qb_p[44:28];
			lum_s5   <= lum_s4;
			alpha_s5 <= alpha_s4;
		end
		if (take6) begin
			red_s6   <= or_p[23:16];
			green_s6 <= og_p[23:16];
			blue_s6  <= ob_p[23:16];
			alpha_s6 <= alpha_s5;
		end
	end

	assign tinted.red_out   = red_s6;
	assign tinted.green_out = green_s6;
	assign tinted.blue_out  = blue_s6;
	assign tinted.alpha_out = alpha_s6;

	// checks
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("input blocked with a free stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> v_s1)
		else $error("accepted word not in stage 1");

	a_stage5_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !take5 |=> v_s5 && $stable(m1_s5) && $stable(qr_s5) && $stable(lum_s5))
		else $error("stalled stage 5 word changed");

	a_hsl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (18'(m1_s4) + 18'(d_s4)) <= 18'(Q_ONE))
		else $error("m2 above one");

endmodule

### tb/tb_hsl_colorize_pixel_unit.sv
// Self-checking testbench for the HSL colorize pixel unit with a tint scoreboard.
module tb_hsl_colorize_pixel_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import hcp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 16;
	localparam int PHASE_WORDS = 106;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		chan_t alpha;
	} pixel_t;

	typedef struct {
		int hue;
		int sat;
		int light;
		int alpha;
	} tint_setting_t;

	class tint_scoreboard;
		bit [8:0] hue_reg;
		bit [6:0] sat_reg;
		bit [7:0] light_reg;
		bit       alpha_reg;
		pixel_t   pending_tints[$];
		int       fails;

		function new();
			hue_reg   = HUE_RST;
			sat_reg   = SAT_RST;
			light_reg = LIGHT_RST;
			alpha_reg = 1'b0;
			fails     = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_HUE:   hue_reg   = val[8:0];
				REG_SAT:   sat_reg   = val[6:0];
				REG_LIGHT: light_reg = val[7:0];
				REG_ALPHA: alpha_reg = val[0];
				default: ;
			endcase
		endfunction

		function bit [31:0] hsl_ramp(bit [31:0] m1, bit [31:0] m2, int p);
			bit [31:0] d;
			d = m2 - m1;
			if (p > 360) begin
				p -= 360;
			end else if (p < 0) begin
				p += 360;
			end
			if (p < 60) return m1 + (d * 32'(p)) / 32'd60;
			if (p < 180) return m2;
			if (p < 240) return m1 + (d * 32'(240 - p)) / 32'd60;
			return m1;
		endfunction

		function pixel_t colorize(pixel_t px);
			bit [31:0] hue, sat, lum, k, s, l, m1, m2, vr, vg, vb;
			bit [63:0] prod;
			int light;
			pixel_t res;
			hue = (hue_reg >= 9'd360) ? 32'(hue_reg) - 32'd360 : 32'(hue_reg);
			sat = (sat_reg > 7'd100) ? 32'd100 : 32'(sat_reg);
			light = int'($signed(light_reg));
			if (light < -100) light = -100;
			lum = ((32'(px.red) * 32'(W_RED)) >> 16) + ((32'(px.green) * 32'(W_GREEN)) >> 16)
				+ ((32'(px.blue) * 32'(W_BLUE)) >> 16);
			if (light > 0) begin
				k = 32'(100 - light);
				lum = (lum * k) / 32'd100;
				lum = lum + 32'd255 - (k * 32'd255 + 32'd99) / 32'd100;
			end else if (light < 0) begin
				lum = (lum * 32'(light + 100)) / 32'd100;
			end
			lum &= 32'hFF;
			s = (sat * 32'd65536 + 32'd50) / 32'd100;
			l = (lum * 32'd65536 + 32'd127) / 32'd255;
			if (l <= 32'd32768) begin
				prod = 64'(l) * 64'(32'd65536 + s);
				m2 = 32'(prod >> 16);
			end else begin
				prod = 64'(l) * 64'(s);
				m2 = l + s - 32'(prod >> 16);
			end
			m1 = 2 * l - m2;
			vr = hsl_ramp(m1, m2, int'(hue) + 120);
			vg = hsl_ramp(m1, m2, int'(hue));
			vb = hsl_ramp(m1, m2, int'(hue) - 120);
			res.red   = 8'((lum * vr) >> 16);
			res.green = 8'((lum * vg) >> 16);
			res.blue  = 8'((lum * vb) >> 16);
			res.alpha = alpha_reg ? px.alpha : 8'd0;
			return res;
		endfunction

		function void note_pixel(pixel_t px);
			pending_tints.push_back(colorize(px));
		endfunction

		function void check_tinted(pixel_t got);
			pixel_t want;
			if (pending_tints.size() == 0) begin
				$display("%0t: tinted word %h with none expected", $time, got);
				fails++;
				return;
			end
			want = pending_tints.pop_front();
			if (got.red !== want.red) begin
				$display("%0t: red_out expected %0d actual %0d", $time, want.red, got.red);
				fails++;
			end
			if (got.green !== want.green) begin
				$display("%0t: green_out expected %0d actual %0d", $time, want.green, got.green);
				fails++;
			end
			if (got.blue !== want.blue) begin
				$display("%0t: blue_out expected %0d actual %0d", $time, want.blue, got.blue);
				fails++;
			end
			if (got.alpha !== want.alpha) begin
				$display("%0t: alpha_out expected %0d actual %0d", $time, want.alpha, got.alpha);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;

	hcp_in_if  pix_if ();
	hcp_out_if tint_if ();

	hsl_colorize_pixel_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_if),
		.tinted  (tint_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tint_scoreboard sb = new();
	int cycles    = 0;
	int idle_pct  = 0;
	int stall_pct = 0;
	bit hold_req  = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && tint_if.valid === 1'b1 && tint_if.ready === 1'b1) begin
			sb.check_tinted({tint_if.red_out, tint_if.green_out, tint_if.blue_out,
				tint_if.alpha_out});
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		tint_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				tint_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
				tint_if.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			tint_if.ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_pixel(input pixel_t px);
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		pix_if.valid    <= 1'b1;
		pix_if.red_in   <= px.red;
		pix_if.green_in <= px.green;
		pix_if.blue_in  <= px.blue;
		pix_if.alpha_in <= px.alpha;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
		sb.note_pixel(px);
	endtask

	task automatic drain();
		pix_if.valid <= 1'b0;
		while (sb.pending_tints.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic chan_t rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	pixel_t directed_px[8] = '{
		'{8'd0, 8'd0, 8'd0, 8'h00}, '{8'd255, 8'd255, 8'd255, 8'hFF},
		'{8'd255, 8'd0, 8'd0, 8'h80}, '{8'd0, 8'd255, 8'd0, 8'h01},
		'{8'd0, 8'd0, 8'd255, 8'hFE}, '{8'd128, 8'd128, 8'd128, 8'h7F},
		'{8'd1, 8'd2, 8'd3, 8'h55}, '{8'd254, 8'd253, 8'd252, 8'hAA}
	};

	// extremes first, including out-of-range hue, saturation and lightness
	tint_setting_t fixed_settings[8] = '{
		'{0, 100, 100, 1}, '{359, 0, -100, 1}, '{360, 127, -128, 0},
		'{511, 101, -1, 1}, '{240, 100, 1, 0}, '{120, 50, 0, 1},
		'{60, 75, 127, 1}, '{300, 25, -101, 0}
	};

	initial begin
		tint_setting_t cfg;
		pixel_t px;
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		pix_if.valid    <= 1'b0;
		pix_if.red_in   <= '0;
		pix_if.green_in <= '0;
		pix_if.blue_in  <= '0;
		pix_if.alpha_in <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero lightness, alpha disabled
		foreach (directed_px[i]) send_pixel(directed_px[i]);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 8) begin
				cfg = fixed_settings[ph];
			end else begin
				cfg.hue   = ($urandom_range(0, 3) == 0) ? $urandom_range(360, 511)
					: $urandom_range(0, 359);
				cfg.sat   = $urandom_range(0, 127);
				cfg.light = int'($urandom_range(0, 255)) - 128;
				cfg.alpha = $urandom_range(0, 1);
			end
			apb_write(REG_HUE, 32'(cfg.hue));
			apb_write(REG_SAT, 32'(cfg.sat));
			apb_write(REG_LIGHT, 32'(cfg.light) & 32'hFF);
			apb_write(REG_ALPHA, 32'(cfg.alpha));

			if (ph >= PHASES - 3) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
			end
			// long receiver hold-off while words keep coming
			if (ph == 3) hold_req = 1'b1;

			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n < 8) begin
					px = directed_px[n];
				end else begin
					px.red   = rand_chan();
					px.green = rand_chan();
					px.blue  = rand_chan();
					px.alpha = rand_chan();
				end
				send_pixel(px);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.fails == 0 && sb.pending_tints.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
